>>> src/nrmc_pkg.sv
// ----------------------------------------------------------------------------
// nrmc_pkg
// Shared types, character codes and helpers of the RMC sentence field
// extractor.
// ----------------------------------------------------------------------------
package nrmc_pkg;

	localparam int NUM_FIELDS = 6;
	localparam int NUM_SLOTS  = 5;
	localparam int LEN_W      = 4;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_COMMA  = 8'h2C;

	localparam logic [2:0] COMMAS_FULL = 3'd7;
	localparam logic [2:0] ID_NONE     = 3'd0;

	typedef logic [NUM_FIELDS-1:0][LEN_W-1:0] nrmc_lens_t;

	typedef struct packed {
		logic       start;
		logic       error;
		logic       status_a;
		nrmc_lens_t lens;
	} nrmc_frame_t;

	typedef struct packed {
		logic       found;
		logic [2:0] slot;
	} nrmc_slot_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SINGLE = 4'b0010,
		ST_RD     = 4'b0100,
		ST_LD     = 4'b1000
	} nrmc_state_t;

	// Output slots carry fields 1, 3, 4, 5 and 6 in that order.
	function automatic logic [2:0] slot_id(input logic [2:0] slot);
		logic [2:0] id;
		case (slot)
			3'd0:    id = 3'd1;
			3'd1:    id = 3'd3;
			3'd2:    id = 3'd4;
			3'd3:    id = 3'd5;
			3'd4:    id = 3'd6;
			default: id = ID_NONE;
		endcase
		return id;
	endfunction

	function automatic nrmc_slot_t next_slot(input nrmc_lens_t lens, input logic [2:0] from);
		nrmc_slot_t r;
		logic [2:0] fidx;
		r = '0;
		for (int k = 0; k < NUM_SLOTS; k++) begin
			fidx = slot_id(3'(k)) - 3'd1;
			if (!r.found && (3'(k) >= from) && (lens[fidx] != '0)) begin
				r.found = 1'b1;
				r.slot  = 3'(k);
			end
		end
		return r;
	endfunction

endpackage

>>> src/nrmc_ram.sv
// ----------------------------------------------------------------------------
// nrmc_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module nrmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 72,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/nrmc_rx.sv
// ----------------------------------------------------------------------------
// nrmc_rx
// Byte parser: tracks the sentence, counts commas, writes field characters
// into the character RAM and flags the end of an RMC sentence.
// ----------------------------------------------------------------------------
module nrmc_rx import nrmc_pkg::*; #(
	parameter int MAX_SENTENCE = 128,
	parameter int FIELD_LEN    = 12,
	localparam int AW = $clog2(NUM_FIELDS * FIELD_LEN),
	localparam int PW = $clog2(MAX_SENTENCE + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          byte_en,
	input  logic [7:0]    rx_byte,
	output logic          ram_we,
	output logic [AW-1:0] ram_waddr,
	output logic [7:0]    ram_wdata,
	output nrmc_frame_t   frame
);

	logic          in_sentence_q;
	logic [PW-1:0] pos_q;
	logic [1:0]    type_q;
	logic [2:0]    commas_q;
	nrmc_lens_t    lens_q;
	logic          status_a_q;

	logic          live;
	logic          in_field;
	logic [2:0]    fidx;
	logic [LEN_W-1:0] cur_len;
	logic          store;

	always_comb begin
		live      = byte_en && (rx_byte != CH_DOLLAR) && in_sentence_q
			&& (pos_q < PW'(MAX_SENTENCE));
		in_field  = (commas_q != 3'd0) && (commas_q != COMMAS_FULL);
		fidx      = commas_q - 3'd1;
		cur_len   = lens_q[fidx];
		store     = live && (rx_byte != CH_LF) && (rx_byte != CH_COMMA) && in_field
			&& (cur_len < LEN_W'(FIELD_LEN));
		ram_we    = store;
		ram_waddr = AW'(int'(fidx) * FIELD_LEN + int'(cur_len));
		ram_wdata = rx_byte;
		frame.start    = live && (rx_byte == CH_LF) && (type_q == 2'b11);
		frame.error    = commas_q != COMMAS_FULL;
		frame.status_a = status_a_q;
		frame.lens     = lens_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sentence_q <= 1'b0;
			pos_q         <= '0;
			type_q        <= '0;
			commas_q      <= '0;
			lens_q        <= '0;
			status_a_q    <= 1'b0;
		end else if (byte_en && (rx_byte == CH_DOLLAR)) begin
			in_sentence_q <= 1'b1;
			pos_q         <= PW'(1);
			type_q        <= '0;
			commas_q      <= '0;
			lens_q        <= '0;
			status_a_q    <= 1'b0;
		end else if (live) begin
			pos_q <= pos_q + PW'(1);
			if (rx_byte == CH_LF) begin
				in_sentence_q <= 1'b0;
			end else begin
				if ((pos_q == PW'(4)) && (rx_byte == CH_M)) begin
					type_q[0] <= 1'b1;
				end
				if ((pos_q == PW'(5)) && (rx_byte == CH_C)) begin
					type_q[1] <= 1'b1;
				end
				if ((rx_byte == CH_COMMA) && (commas_q != COMMAS_FULL)) begin
					commas_q <= commas_q + 3'd1;
				end
				if (store) begin
					lens_q[fidx] <= cur_len + LEN_W'(1);
					if ((fidx == 3'd1) && (cur_len == '0)) begin
						status_a_q <= rx_byte == CH_A;
					end
				end
			end
		end
	end

endmodule

>>> src/nrmc_emit.sv
// ----------------------------------------------------------------------------
// nrmc_emit
// Readout sequencer: walks the stored characters of the reported fields
// through the RAM read port and presents them in the output register.
// ----------------------------------------------------------------------------
module nrmc_emit import nrmc_pkg::*; #(
	parameter int FIELD_LEN = 12,
	localparam int AW = $clog2(NUM_FIELDS * FIELD_LEN)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  nrmc_frame_t   frame,
	output logic          busy,
	output logic          ram_re,
	output logic [AW-1:0] ram_raddr,
	input  logic [7:0]    ram_rdata,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [23:0]   out_data,
	output logic          out_last
);

	nrmc_state_t      state_q;
	logic [2:0]       slot_q;
	logic [LEN_W-1:0] cpos_q;
	logic             single_err_q;

	logic             ov_q;
	logic [2:0]       oid_q;
	logic [LEN_W-1:0] opos_q;
	logic [7:0]       och_q;
	logic             oval_q;
	logic             oerr_q;
	logic             olast_q;

	logic [2:0]       fidx;
	logic [LEN_W-1:0] flen;
	logic             more_chars;
	nrmc_slot_t       first;
	nrmc_slot_t       after;
	logic             out_free;
	logic             load_out;

	always_comb begin
		fidx       = slot_id(slot_q) - 3'd1;
		flen       = frame.lens[fidx];
		more_chars = (cpos_q + LEN_W'(1)) < flen;
		first      = next_slot(frame.lens, 3'd0);
		after      = next_slot(frame.lens, slot_q + 3'd1);
		out_free   = !ov_q || out_ready;
		load_out   = out_free && ((state_q == ST_SINGLE) || (state_q == ST_LD));
		busy       = state_q != ST_IDLE;
		ram_re     = state_q == ST_RD;
		ram_raddr  = AW'(int'(fidx) * FIELD_LEN + int'(cpos_q));
		out_valid  = ov_q;
		out_data   = {7'd0, oerr_q, oval_q, och_q, opos_q, oid_q};
		out_last   = olast_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			slot_q       <= '0;
			cpos_q       <= '0;
			single_err_q <= 1'b0;
			ov_q         <= 1'b0;
		end else begin
			if (load_out) begin
				ov_q <= 1'b1;
			end else if (ov_q && out_ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (frame.start) begin
						slot_q <= first.slot;
						cpos_q <= '0;
						single_err_q <= frame.error;
						if (frame.error || !first.found) begin
							state_q <= ST_SINGLE;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_SINGLE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RD: begin
					state_q <= ST_LD;
				end
				ST_LD: begin
					if (out_free) begin
						if (more_chars) begin
							cpos_q  <= cpos_q + LEN_W'(1);
							state_q <= ST_RD;
						end else if (after.found) begin
							slot_q  <= after.slot;
							cpos_q  <= '0;
							state_q <= ST_RD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_SINGLE) && out_free) begin
			oid_q   <= ID_NONE;
			opos_q  <= '0;
			och_q   <= '0;
			oval_q  <= !single_err_q && frame.status_a;
			oerr_q  <= single_err_q;
			olast_q <= 1'b1;
		end else if ((state_q == ST_LD) && out_free) begin
			oid_q   <= slot_id(slot_q);
			opos_q  <= cpos_q;
			och_q   <= ram_rdata;
			oval_q  <= frame.status_a;
			oerr_q  <= 1'b0;
			olast_q <= !more_chars && !after.found;
		end
	end

endmodule

>>> src/nmea_rmc_sentence_field_extractor.sv
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_field_extractor
// Parses an NMEA byte stream and reports the characters of the time,
// latitude and longitude fields of every RMC sentence.
//
// Channel  Dir  Payload
// s_*      in   one received byte
// m_*      out  one field character, marker or error result; tlast ends run
//
// A byte is taken every cycle while no report is being sent.
// The end-of-sentence byte starts a report: each stored character is read
// from the RAM, then loaded into the output register; a marker or error
// result is loaded directly. Input is held off until the report is issued.
// A stalled output holds the sequencer; reset is asynchronous, active low.
// ----------------------------------------------------------------------------
module nmea_rmc_sentence_field_extractor import nrmc_pkg::*; #(
	parameter int MAX_SENTENCE = 128,
	parameter int FIELD_LEN    = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [2:0] field_id, [6:3] char_pos, [14:7] char_value,
	                               // [15] position_valid, [16] frame_error
	output logic        m_tlast
);

	localparam int RAM_DEPTH = NUM_FIELDS * FIELD_LEN;
	localparam int AW        = $clog2(RAM_DEPTH);

	nrmc_frame_t   frame;
	logic          busy;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	assign s_tready = !busy;

	nrmc_rx #(
		.MAX_SENTENCE(MAX_SENTENCE),
		.FIELD_LEN   (FIELD_LEN)
	) u_rx (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_en  (s_tvalid && s_tready),
		.rx_byte  (s_tdata),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.frame    (frame)
	);

	nrmc_ram #(
		.WIDTH(8),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	nrmc_emit #(
		.FIELD_LEN(FIELD_LEN)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.frame    (frame),
		.busy     (busy),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (m_tdata),
		.out_last (m_tlast)
	);

`ifndef SYNTHESIS
	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[16]) |-> (m_tlast && (m_tdata[2:0] == ID_NONE)))
		else $error("error result is not a lone final result");

	a_marker_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[2:0] == ID_NONE)) |-> m_tlast)
		else $error("marker result is not final");

	a_no_status_field: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2:0] != 3'd2) && (m_tdata[2:0] != 3'd7))
		else $error("unreported field id emitted");

	a_no_ram_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("RAM written while report is being read");
`endif

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RMC sentence field extractor. It sends a fixed
// table of sentences first, with empty, error and marker cases among them,
// then a random mix of good, short, foreign, cut and overlong sentences and
// line noise. Every accepted byte goes through a behavioral parser that works
// out the characters each sentence should report. The output stream is
// compared with them field by field. The sender runs in bursts and the
// receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module testbench;
	import nrmc_pkg::*;

	localparam int MAX_SENTENCE = 128;
	localparam int FIELD_LEN    = 12;
	localparam int STATUS_FIELD = 1;
	localparam int RANDOM_BYTES = 90;
	localparam int CYCLE_LIMIT  = 400000;
	localparam logic [7:0] CH_V = 8'h56;

	typedef struct packed {
		logic [2:0] field_id;
		logic [3:0] char_pos;
		logic [7:0] char_value;
		logic       position_valid;
		logic       frame_error;
		logic       last;
	} rmc_char_t;

	typedef enum {CHECK_MODEL, NO_REPORT, ERROR_REPORT, MARKER_VOID, MARKER_VALID} row_kind_t;
	typedef enum {LINE_RMC, LINE_SHORT, LINE_OTHER, LINE_NOISE, LINE_CUT, LINE_LONG} line_kind_t;
	typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_TOGGLE} ready_mode_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // [2:0] field_id, [6:3] char_pos, [14:7] char_value,
	                        // [15] position_valid, [16] frame_error
	logic        m_tlast;

	rmc_char_t   report_q[$];
	rmc_char_t   fresh_chars[$];

	logic        in_sentence = 1'b0;
	int          sentence_pos = 0;
	logic [1:0]  type_bits = '0;
	logic [2:0]  commas = '0;
	logic [3:0]  field_len [NUM_FIELDS] = '{default: '0};
	logic [7:0]  field_buf [NUM_FIELDS][FIELD_LEN];
	logic [7:0]  status_ch = '0;

	int          mismatches = 0;
	int          cycle_count = 0;
	int          burst_left = 0;
	int          stall_left = 0;
	ready_mode_t stall_mode = READY_ALWAYS;
	int          chars_checked = 0;
	int          errors_seen = 0;
	int          markers_seen = 0;
	int          lines_sent = 0;
	int          bytes_sent = 0;

	string dir_text[$] = '{
		"zzMC,\n",
		"$GP\n",
		"$GPRMC\n",
		"$GPRMC,1,A,2,N,3,E\n",
		"$GPRMC,,,,,,,\n",
		"$GPRMC,,A,,,,,\n",
		"$GPRMC,,V,,,,,\n",
		"$GPRMC,ABCDEFGHIJKLZ,A,abcdefghijkl,MNOPQRSTUVWX,mnopqrstuvwx,012345678901,\n",
		"$GPRMC,11,A,$GPRMC,22,V,3,S,4,W,\n",
		"$GPRMC,1,VA,2,N,3,E,\n",
		"$XXXMC,5,A,,,,,,\n",
		"$GPRMX,5,A,6,N,7,E,\n",
		"$GPRMC,\377\001,A,\176,\177,\200\201,,\n"
	};
	row_kind_t dir_kind[$] = '{
		NO_REPORT, NO_REPORT, ERROR_REPORT, ERROR_REPORT, MARKER_VOID, MARKER_VALID,
		MARKER_VOID, CHECK_MODEL, CHECK_MODEL, CHECK_MODEL, CHECK_MODEL, NO_REPORT,
		CHECK_MODEL
	};

	nmea_rmc_sentence_field_extractor #(
		.MAX_SENTENCE(MAX_SENTENCE),
		.FIELD_LEN   (FIELD_LEN)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Parses one byte and leaves the characters it reports in fresh_chars.
	function automatic void parse_rmc_byte(input logic [7:0] b);
		int pos;
		int fi;
		int n;
		logic valid;
		rmc_char_t r;
		if (b == CH_DOLLAR) begin
			in_sentence = 1'b1;
			sentence_pos = 1;
			type_bits = '0;
			commas = '0;
			field_len = '{default: '0};
			status_ch = '0;
			return;
		end
		if (!in_sentence || sentence_pos >= MAX_SENTENCE)
			return;
		pos = sentence_pos;
		sentence_pos = pos + 1;
		if (b == CH_LF) begin
			in_sentence = 1'b0;
			valid = (status_ch == CH_A);
			if (type_bits != 2'b11)
				return;
			if (commas < COMMAS_FULL) begin
				r = '{ID_NONE, 4'd0, 8'd0, 1'b0, 1'b1, 1'b1};
				fresh_chars.push_back(r);
				return;
			end
			n = 0;
			for (fi = 0; fi < NUM_FIELDS; fi++) begin
				if (fi != STATUS_FIELD) begin
					for (int i = 0; i < field_len[fi]; i++) begin
						r = '{3'(fi + 1), 4'(i), field_buf[fi][i], valid, 1'b0, 1'b0};
						fresh_chars.push_back(r);
						n++;
					end
				end
			end
			if (n == 0) begin
				r = '{ID_NONE, 4'd0, 8'd0, valid, 1'b0, 1'b1};
				fresh_chars.push_back(r);
			end else begin
				fresh_chars[fresh_chars.size() - 1].last = 1'b1;
			end
			return;
		end
		if (pos == 4 && b == CH_M)
			type_bits[0] = 1'b1;
		if (pos == 5 && b == CH_C)
			type_bits[1] = 1'b1;
		if (b == CH_COMMA) begin
			if (commas < COMMAS_FULL)
				commas = commas + 3'd1;
			return;
		end
		if (commas >= 3'd1 && commas <= 3'(NUM_FIELDS)) begin
			fi = int'(commas) - 1;
			if (field_len[fi] < FIELD_LEN) begin
				if (fi == STATUS_FIELD && field_len[fi] == 0)
					status_ch = b;
				field_buf[fi][field_len[fi]] = b;
				field_len[fi] = field_len[fi] + 4'd1;
			end
		end
	endfunction

	function automatic logic [7:0] field_char();
		logic [7:0] c;
		case ($urandom_range(0, 9)) inside
			0: c = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			1, 2: begin
				c = 8'($urandom_range(0, 255));
				if (c == CH_DOLLAR || c == CH_COMMA || c == CH_LF)
					c = c ^ 8'h80;
			end
			default: c = 8'($urandom_range(8'h2E, 8'h39));
		endcase
		return c;
	endfunction

	task automatic send_bytes(input logic [7:0] bytes[$], input bit use_model);
		int gap;
		foreach (bytes[i]) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				                                          : $urandom_range(1, 8);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= bytes[i];
			do @(posedge clk); while (!s_tready);
			burst_left--;
			parse_rmc_byte(bytes[i]);
			if (use_model)
				foreach (fresh_chars[k]) report_q.push_back(fresh_chars[k]);
			fresh_chars.delete();
		end
	endtask

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (report_q.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = ready_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(20, 150);
		end
		stall_left--;
		case (stall_mode)
			READY_ALWAYS: m_tready <= 1'b1;
			READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
			READY_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
			default:      m_tready <= ~m_tready;
		endcase
	end

	always @(posedge clk) begin
		rmc_char_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (report_q.size() == 0) begin
				$error("unexpected result: field_id %0d char_pos %0d char_value %0h",
				       m_tdata[2:0], m_tdata[6:3], m_tdata[14:7]);
				mismatches++;
			end else begin
				want = report_q.pop_front();
				chars_checked++;
				if (want.frame_error)
					errors_seen++;
				else if (want.field_id == ID_NONE)
					markers_seen++;
				if (m_tdata[2:0] !== want.field_id) begin
					$error("field_id: expected %0d, got %0d", want.field_id, m_tdata[2:0]);
					mismatches++;
				end
				if (m_tdata[6:3] !== want.char_pos) begin
					$error("char_pos: expected %0d, got %0d", want.char_pos, m_tdata[6:3]);
					mismatches++;
				end
				if (m_tdata[14:7] !== want.char_value) begin
					$error("char_value: expected %0h, got %0h", want.char_value,
					       m_tdata[14:7]);
					mismatches++;
				end
				if (m_tdata[15] !== want.position_valid) begin
					$error("position_valid: expected %0b, got %0b", want.position_valid,
					       m_tdata[15]);
					mismatches++;
				end
				if (m_tdata[16] !== want.frame_error) begin
					$error("frame_error: expected %0b, got %0b", want.frame_error,
					       m_tdata[16]);
					mismatches++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, m_tlast);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		string      txt;
		logic [7:0] line[$];
		line_kind_t kind;
		int         roll;
		int         nf;
		int         len;
		int         random_end;
		rmc_char_t  r;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;

		txt = "$GPRMC,";
		repeat (122) txt = {txt, "9"};
		dir_text.push_back({txt, "\n"});
		dir_kind.push_back(NO_REPORT);
		dir_text.push_back("1,2\n");
		dir_kind.push_back(NO_REPORT);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_text[row]) begin
			txt = dir_text[row];
			line.delete();
			for (int j = 0; j < txt.len(); j++) line.push_back(txt[j]);
			send_bytes(line, dir_kind[row] == CHECK_MODEL);
			lines_sent++;
			bytes_sent += line.size();
			case (dir_kind[row])
				ERROR_REPORT: begin
					r = '{ID_NONE, 4'd0, 8'd0, 1'b0, 1'b1, 1'b1};
					report_q.push_back(r);
				end
				MARKER_VOID: begin
					r = '{ID_NONE, 4'd0, 8'd0, 1'b0, 1'b0, 1'b1};
					report_q.push_back(r);
				end
				MARKER_VALID: begin
					r = '{ID_NONE, 4'd0, 8'd0, 1'b1, 1'b0, 1'b1};
					report_q.push_back(r);
				end
				default: ;
			endcase
		end
		hold_until_drained();

		random_end = bytes_sent + RANDOM_BYTES;
		while (bytes_sent < random_end) begin
			roll = $urandom_range(0, 199);
			if (roll < 110)      kind = LINE_RMC;
			else if (roll < 130) kind = LINE_SHORT;
			else if (roll < 150) kind = LINE_OTHER;
			else if (roll < 170) kind = LINE_NOISE;
			else if (roll < 196) kind = LINE_CUT;
			else                 kind = LINE_LONG;
			line.delete();
			if (kind == LINE_NOISE) begin
				repeat ($urandom_range(1, 6)) line.push_back(8'($urandom_range(0, 255)));
			end else if (kind == LINE_LONG) begin
				line = '{CH_DOLLAR, "G", "P", "R", CH_M, CH_C};
				repeat ($urandom_range(115, 140))
					line.push_back(($urandom_range(0, 4) == 0) ? CH_COMMA : field_char());
				line.push_back(CH_LF);
			end else begin
				line.push_back(CH_DOLLAR);
				repeat (2) line.push_back(8'($urandom_range(8'h41, 8'h5A)));
				if (kind == LINE_OTHER) begin
					repeat (3) line.push_back(8'($urandom_range(8'h41, 8'h5A)));
				end else begin
					line.push_back("R");
					line.push_back(CH_M);
					line.push_back(CH_C);
				end
				nf = (kind == LINE_SHORT) ? $urandom_range(0, 5) : NUM_FIELDS;
				for (int k = 0; k < nf; k++) begin
					line.push_back(CH_COMMA);
					if (k == STATUS_FIELD) begin
						case ($urandom_range(0, 5)) inside
							0, 1, 2: line.push_back(CH_A);
							3:       line.push_back(CH_V);
							4:       line.push_back(field_char());
							default: ;
						endcase
					end else begin
						len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 15)
						                                   : $urandom_range(0, 3);
						repeat (len) line.push_back(field_char());
					end
				end
				if (kind != LINE_SHORT) begin
					line.push_back(CH_COMMA);
					repeat ($urandom_range(0, 6))
						line.push_back(($urandom_range(0, 3) == 0) ? CH_COMMA : field_char());
				end
				if (kind != LINE_CUT)
					line.push_back(CH_LF);
			end
			send_bytes(line, 1'b1);
			bytes_sent += line.size();
			if (kind != LINE_NOISE)
				lines_sent++;
			if ($urandom_range(0, 7) == 0)
				hold_until_drained();
		end

		hold_until_drained();
		repeat (150) @(posedge clk);

		$display("Sent %0d sentences in %0d bytes; checked %0d reported characters,",
		         lines_sent, bytes_sent, chars_checked);
		$display("including %0d frame errors and %0d empty-frame markers.",
		         errors_seen, markers_seen);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

>>> sim.f
src/nrmc_pkg.sv
src/nrmc_ram.sv
src/nrmc_rx.sv
src/nrmc_emit.sv
src/nmea_rmc_sentence_field_extractor.sv
bench/testbench.sv
